>>> design/vici_message_validator_core_macros.svh
// Assertion macros for the checker of the message validator.
`ifndef VICI_MESSAGE_VALIDATOR_CORE_MACROS_SVH
`define VICI_MESSAGE_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define VMV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define VMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/vmv_pkg.sv
// Types and constants for the message validator.
package vmv_pkg;

  // Width of value length counts (8 to 16).
  localparam int VALUE_LEN_BITS = 16;
  localparam int REM_W          = (VALUE_LEN_BITS > 8) ? VALUE_LEN_BITS : 8;
  localparam logic [16:0] VLEN_MAX = 17'((1 << VALUE_LEN_BITS) - 1);

  localparam int STATUS_W = 3;
  localparam int OUT_W    = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_BAD_ELEM  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // Packet types
  localparam logic [7:0] PT_CMD_REQUEST   = 8'd0;
  localparam logic [7:0] PT_CMD_RESPONSE  = 8'd1;
  localparam logic [7:0] PT_CMD_UNKNOWN   = 8'd2;
  localparam logic [7:0] PT_EVT_REGISTER  = 8'd3;
  localparam logic [7:0] PT_EVT_UNREG     = 8'd4;
  localparam logic [7:0] PT_EVT_CONFIRM   = 8'd5;
  localparam logic [7:0] PT_EVT_UNKNOWN   = 8'd6;
  localparam logic [7:0] PT_EVENT         = 8'd7;

  // Element types
  localparam logic [7:0] EL_SECTION_START = 8'd1;
  localparam logic [7:0] EL_SECTION_END   = 8'd2;
  localparam logic [7:0] EL_KEY_VALUE     = 8'd3;
  localparam logic [7:0] EL_LIST_START    = 8'd4;
  localparam logic [7:0] EL_LIST_ITEM     = 8'd5;
  localparam logic [7:0] EL_LIST_END      = 8'd6;

  typedef enum logic [12:0] {
    PH_TYPE     = 13'b0000000000001,
    PH_SIMPLE   = 13'b0000000000010,
    PH_HDR_LEN  = 13'b0000000000100,
    PH_HDR_NAME = 13'b0000000001000,
    PH_ELEM     = 13'b0000000010000,
    PH_SL_LEN   = 13'b0000000100000,
    PH_SL_NAME  = 13'b0000001000000,
    PH_KV_LEN   = 13'b0000010000000,
    PH_KV_NAME  = 13'b0000100000000,
    PH_VLEN_HI  = 13'b0001000000000,
    PH_VLEN_LO  = 13'b0010000000000,
    PH_VDATA    = 13'b0100000000000,
    PH_DRAIN    = 13'b1000000000000
  } phase_t;

  // Verdict handed from the parser to the output stage.
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] msg_type;
  } verdict_t;

endpackage

>>> design/vmv_parser.sv
// Byte-wide parse state machine of the message validator.
module vmv_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        body_byte,
  input  logic              last_byte,
  output vmv_pkg::verdict_t verdict
);
  import vmv_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [7:0]       type_r, type_nxt;
  status_t          err_r, err_nxt;
  logic [REM_W-1:0] rem_dec;
  logic [16:0]      vlen;
  status_t          fin_status;

  assign rem_dec = rem_r - REM_W'(1);
  assign vlen    = {1'b0, len_hi_r, body_byte};

  // Advance the parse by one byte
  always_comb begin
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    len_hi_nxt = len_hi_r;
    type_nxt   = type_r;
    err_nxt    = err_r;
    unique case (phase_r)
      PH_TYPE: begin
        type_nxt = body_byte;
        if (body_byte == PT_CMD_RESPONSE || body_byte == PT_CMD_UNKNOWN ||
            body_byte == PT_EVT_CONFIRM || body_byte == PT_EVT_UNKNOWN) begin
          phase_nxt = PH_SIMPLE;
        end else if (body_byte == PT_CMD_REQUEST || body_byte == PT_EVT_REGISTER ||
                     body_byte == PT_EVT_UNREG || body_byte == PT_EVENT) begin
          phase_nxt = PH_HDR_LEN;
        end else begin
          if (err_r == ST_OK) err_nxt = ST_BAD_TYPE;
          phase_nxt = PH_DRAIN;
        end
      end
      PH_SIMPLE: begin
        if (err_r == ST_OK) err_nxt = ST_BAD_HDR;
        phase_nxt = PH_DRAIN;
      end
      PH_HDR_LEN: begin
        if (body_byte == 8'd0) begin
          if (last_byte) begin
            if (err_r == ST_OK) err_nxt = ST_BAD_HDR;
            phase_nxt = PH_DRAIN;
          end else begin
            phase_nxt = PH_ELEM;
          end
        end else begin
          rem_nxt   = REM_W'(body_byte);
          phase_nxt = PH_HDR_NAME;
        end
      end
      PH_HDR_NAME, PH_SL_NAME, PH_VDATA: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_ELEM;
      end
      PH_KV_NAME: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_VLEN_HI;
      end
      PH_ELEM: begin
        if (body_byte == EL_SECTION_END || body_byte == EL_LIST_END) begin
          phase_nxt = PH_ELEM;
        end else if (body_byte == EL_SECTION_START || body_byte == EL_LIST_START) begin
          phase_nxt = PH_SL_LEN;
        end else if (body_byte == EL_KEY_VALUE) begin
          phase_nxt = PH_KV_LEN;
        end else if (body_byte == EL_LIST_ITEM) begin
          phase_nxt = PH_VLEN_HI;
        end else begin
          if (err_r == ST_OK) err_nxt = ST_BAD_ELEM;
          phase_nxt = PH_DRAIN;
        end
      end
      PH_SL_LEN: begin
        if (body_byte == 8'd0) begin
          phase_nxt = PH_ELEM;
        end else begin
          rem_nxt   = REM_W'(body_byte);
          phase_nxt = PH_SL_NAME;
        end
      end
      PH_KV_LEN: begin
        if (body_byte == 8'd0) begin
          phase_nxt = PH_VLEN_HI;
        end else begin
          rem_nxt   = REM_W'(body_byte);
          phase_nxt = PH_KV_NAME;
        end
      end
      PH_VLEN_HI: begin
        len_hi_nxt = body_byte;
        phase_nxt  = PH_VLEN_LO;
      end
      PH_VLEN_LO: begin
        if (vlen > VLEN_MAX) begin
          if (err_r == ST_OK) err_nxt = ST_TRUNCATED;
          phase_nxt = PH_DRAIN;
        end else if (vlen == 17'd0) begin
          phase_nxt = PH_ELEM;
        end else begin
          rem_nxt   = REM_W'(vlen);
          phase_nxt = PH_VDATA;
        end
      end
      PH_DRAIN: begin
        phase_nxt = PH_DRAIN;
      end
      default: begin
        if (err_r == ST_OK) err_nxt = ST_TRUNCATED;
        phase_nxt = PH_DRAIN;
      end
    endcase
  end

  // Judge the message from where the parse stands after this byte
  always_comb begin
    priority if (err_nxt != ST_OK) begin
      fin_status = err_nxt;
    end else if (phase_nxt == PH_ELEM || phase_nxt == PH_SIMPLE) begin
      fin_status = ST_OK;
    end else if (phase_nxt == PH_HDR_LEN || phase_nxt == PH_HDR_NAME) begin
      fin_status = ST_BAD_HDR;
    end else begin
      fin_status = ST_TRUNCATED;
    end
  end

  assign verdict.valid    = step && last_byte;
  assign verdict.status   = fin_status;
  assign verdict.msg_type = type_nxt;

  // Hold state between beats; return to idle after the last beat
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r  <= PH_TYPE;
      rem_r    <= '0;
      len_hi_r <= '0;
      type_r   <= '0;
      err_r    <= ST_OK;
    end else if (step) begin
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      len_hi_r <= len_hi_nxt;
      type_r   <= type_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

>>> design/vici_message_validator_core.sv
// Top level of the message validator: input stage, parser and result register.
//
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | tdata[7:0] body_byte, tlast last_byte
//  out_    | out | out_tvalid / out_tready | tdata[2:0] status, [10:3] message_type
//
// One byte per cycle is accepted back to back while the output is not stalled; the
// tlast beat is registered in the input stage, then its verdict in the result register,
// one beat per message and none for other bytes. Reset (rst_n low, synchronous) empties
// both stages and puts the parser at the packet type. A stalled output holds its beat;
// an empty input stage still takes one more beat, then in_tready drops until the result is taken.
module vici_message_validator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] body_byte
  input  logic                      in_tlast,   // last_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [vmv_pkg::OUT_W-1:0] out_tdata   // [2:0] status, [10:3] message_type
);
  import vmv_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       advance;
  logic       step;
  verdict_t   verdict;
  logic       out_valid_r;
  status_t    out_status_r;
  logic [7:0] out_type_r;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Input stage: take a beat whenever the stage is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  vmv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .body_byte (in_byte_r),
    .last_byte (in_last_r),
    .verdict   (verdict)
  );

  // Result register: load on a verdict, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= verdict.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && verdict.valid) begin
      out_status_r <= verdict.status;
      out_type_r   <= verdict.msg_type;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - STATUS_W - 8)'(0), out_type_r, out_status_r};

endmodule

>>> design/vmv_checker.sv
// Port-level checker for the message validator, bound to the top level.
`include "vici_message_validator_core_macros.svh"

module vmv_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [vmv_pkg::OUT_W-1:0] out_tdata
);
  import vmv_pkg::*;

  // A stalled result beat holds
  `VMV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // Input backs up only behind a stalled result
  `VMV_ASSERT_NOW(a_in_backpressure, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled without a stalled result")

  // Status in range and padding zero
  `VMV_ASSERT_NOW(a_out_code, clk, rst_n, out_tvalid, out_tdata[2:0] <= ST_TRUNCATED && out_tdata[OUT_W-1:11] == '0, "malformed result beat")

  // Bad type is reported only for a type byte outside the known set
  `VMV_ASSERT_NOW(a_bad_type, clk, rst_n, out_tvalid && out_tdata[2:0] == ST_BAD_TYPE, out_tdata[10:6] != 5'd0, "bad type reported for a known type")

endmodule

bind vici_message_validator_core vmv_checker u_vmv_checker (.*);
